>>> rtl/spcs_pkg.sv
// ----------------------------------------------------------------------------
// spcs_pkg
// Shared types and constants for the strict priority call server.
// ----------------------------------------------------------------------------
package spcs_pkg;

	localparam int NUM_CLASSES_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W    = 16;
	localparam int CLASS_W = 2;
	localparam int DUR_W   = 16;
	localparam int ENTRY_W = ID_W + DUR_W;	// stored word: {id, duration}

	localparam logic MODE_ARRIVAL = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	typedef enum logic [1:0] {
		KIND_QUEUED    = 2'd0,
		KIND_DROPPED   = 2'd1,
		KIND_ANSWERED  = 2'd2,
		KIND_NO_ANSWER = 2'd3
	} result_kind_t;

	typedef struct packed {
		logic               mode;
		logic [ID_W-1:0]    caller_id;
		logic [CLASS_W-1:0] call_class;
		logic [DUR_W-1:0]   call_duration;
	} item_t;

	typedef struct packed {
		result_kind_t       result_kind;
		logic [ID_W-1:0]    answered_id;
		logic [CLASS_W-1:0] answered_class;
		logic               server_busy;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_EXEC   = 2'd1,
		ST_ANSWER = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;	// latch the accepted item
		logic arrive;	// push or drop, load result
		logic tick;	// tick without answer, load result
		logic pop;	// pop the highest waiting class, start queue read
		logic answer;	// load answered result, reload countdown
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
		logic busy;
		logic any_waiting;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/spcs_ctrl.sv
// ----------------------------------------------------------------------------
// spcs_ctrl
// Sequencer: capture an item, execute it, wait for the queue read on a pop.
// ----------------------------------------------------------------------------
module spcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  spcs_pkg::dp_status_t sts,
	output spcs_pkg::ctrl_cmd_t  cmd
);

	spcs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			spcs_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = spcs_pkg::ST_EXEC;
				end
			end
			spcs_pkg::ST_EXEC: begin
				if (sts.is_tick && !sts.busy && sts.any_waiting) begin
					cmd.pop = 1'b1;
					state_d = spcs_pkg::ST_ANSWER;
				end else if (sts.out_free) begin
					if (sts.is_tick) begin
						cmd.tick = 1'b1;
					end else begin
						cmd.arrive = 1'b1;
					end
					state_d = spcs_pkg::ST_IDLE;
				end
			end
			spcs_pkg::ST_ANSWER: begin
				if (sts.out_free) begin
					cmd.answer = 1'b1;
					state_d    = spcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spcs_pkg::ST_IDLE;
			end
		endcase
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.arrive, cmd.tick, cmd.pop, cmd.answer}))
		else $error("more than one datapath command");

	a_pop_then_answer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> state_q == spcs_pkg::ST_ANSWER)
		else $error("pop not followed by answer wait");

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == spcs_pkg::ST_EXEC)
		else $error("accepted item not executed");

endmodule

>>> rtl/spcs_dp.sv
// ----------------------------------------------------------------------------
// spcs_dp
// Datapath: per-class queue pointers, queue memory, busy countdown and the
// result register.
// ----------------------------------------------------------------------------
module spcs_dp #(
	parameter int NUM_CLASSES = spcs_pkg::NUM_CLASSES_DEF,
	parameter int QUEUE_DEPTH = spcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spcs_pkg::ctrl_cmd_t  cmd,
	output spcs_pkg::dp_status_t sts,
	input  spcs_pkg::item_t      item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output spcs_pkg::result_t    result
);

	localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W     = CNT_W + 1;
	localparam int MEM_DEPTH = NUM_CLASSES * (2 ** PTR_W);
	localparam int ADDR_W    = CLS_W + PTR_W;

	spcs_pkg::item_t   item_q;
	logic [PTR_W-1:0]  head_q [NUM_CLASSES];
	logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
	logic [spcs_pkg::DUR_W-1:0]   busy_q;
	logic [spcs_pkg::ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [spcs_pkg::ENTRY_W-1:0] rd_data_q;
	logic [CLS_W-1:0]  pop_cls_q;
	logic              out_valid_q;
	spcs_pkg::result_t out_q;

	logic [CLS_W-1:0]  cls_idx;
	logic              cls_ok;
	logic              push_ok;
	logic [SUM_W-1:0]  slot_sum;
	logic [PTR_W-1:0]  slot;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [CLS_W-1:0]  sel_cls;
	logic              any_waiting;
	logic [spcs_pkg::DUR_W-1:0] rd_dur;
	logic [spcs_pkg::DUR_W-1:0] served_left;
	logic              load;
	spcs_pkg::result_t out_d;

	// arrival: class check, full check, tail slot
	assign cls_idx = CLS_W'(item_q.call_class);
	assign cls_ok  = int'(item_q.call_class) < NUM_CLASSES;
	assign push_ok = cls_ok ? (cnt_q[cls_idx] != CNT_W'(QUEUE_DEPTH)) : 1'b0;

	assign slot_sum = SUM_W'(head_q[cls_idx]) + SUM_W'(cnt_q[cls_idx]);
	assign slot     = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
			PTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
	assign wr_addr  = {cls_idx, slot};

	// highest non-empty class wins
	always_comb begin
		sel_cls     = '0;
		any_waiting = 1'b0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (cnt_q[c] != '0) begin
				sel_cls     = CLS_W'(c);
				any_waiting = 1'b1;
			end
		end
	end
	assign rd_addr = {sel_cls, head_q[sel_cls]};

	// zero duration is served as one tick
	assign rd_dur      = rd_data_q[spcs_pkg::DUR_W-1:0];
	assign served_left = (rd_dur == '0) ? '0 : rd_dur - 1'b1;

	assign load = cmd.arrive || cmd.tick || cmd.answer;

	always_comb begin
		out_d = '0;
		if (cmd.arrive) begin
			out_d.result_kind    = push_ok ? spcs_pkg::KIND_QUEUED : spcs_pkg::KIND_DROPPED;
			out_d.answered_id    = item_q.caller_id;
			out_d.answered_class = item_q.call_class;
			out_d.server_busy    = busy_q != '0;
		end else if (cmd.answer) begin
			out_d.result_kind    = spcs_pkg::KIND_ANSWERED;
			out_d.answered_id    = rd_data_q[spcs_pkg::ENTRY_W-1 -: spcs_pkg::ID_W];
			out_d.answered_class = spcs_pkg::CLASS_W'(pop_cls_q);
			out_d.server_busy    = served_left != '0;
		end else begin
			out_d.result_kind    = spcs_pkg::KIND_NO_ANSWER;
			out_d.server_busy    = busy_q > spcs_pkg::DUR_W'(1);
		end
	end

	// payload registers and queue memory
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.arrive && push_ok) begin
			mem[wr_addr] <= {item_q.caller_id, item_q.call_duration};
		end
		if (cmd.pop) begin
			rd_data_q <= mem[rd_addr];
			pop_cls_q <= sel_cls;
		end
		if (load) begin
			out_q <= out_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
			busy_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.arrive && push_ok) begin
				cnt_q[cls_idx] <= cnt_q[cls_idx] + 1'b1;
			end
			if (cmd.pop) begin
				head_q[sel_cls] <= (head_q[sel_cls] == PTR_W'(QUEUE_DEPTH - 1)) ?
						'0 : head_q[sel_cls] + 1'b1;
				cnt_q[sel_cls]  <= cnt_q[sel_cls] - 1'b1;
			end
			if (cmd.tick && busy_q != '0) begin
				busy_q <= busy_q - 1'b1;
			end
			if (cmd.answer) begin
				busy_q <= served_left;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.is_tick     = item_q.mode == spcs_pkg::MODE_TICK;
	assign sts.busy        = busy_q != '0;
	assign sts.any_waiting = any_waiting;
	assign sts.out_free    = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || result_ready))
		else $error("result register overwritten before transfer");

	a_busy_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.server_busy == (busy_q != '0))
		else $error("server_busy disagrees with countdown");

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cnt_chk
		a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
			cnt_q[g] <= CNT_W'(QUEUE_DEPTH))
			else $error("queue count beyond depth");
	end

endmodule

>>> rtl/strict_priority_call_server_core.sv
// ----------------------------------------------------------------------------
// strict_priority_call_server_core
// Four-class strict priority call queue with a single countdown server.
// ----------------------------------------------------------------------------
// Timing: IDLE captures an item; arrivals and ticks without an answer load
//   the result in EXEC, an answering tick in ANSWER after the queue read.
// Flow: a new item is taken only in IDLE, after the previous one has loaded
//   its result; loading a result waits until the result register is free.
// Reset: arst_n clears queue heads, counts, the busy countdown and the
//   result valid flag; the queue memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module strict_priority_call_server_core #(
	parameter int NUM_CLASSES = spcs_pkg::NUM_CLASSES_DEF,
	parameter int QUEUE_DEPTH = spcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel: one arrival or one tick per transfer
	input  logic              item_valid,
	output logic              item_ready,
	input  spcs_pkg::item_t   item,
	// output channel: exactly one result per item
	output logic              result_valid,
	input  logic              result_ready,
	output spcs_pkg::result_t result
);

	// Command and status between sequencer and datapath.
	spcs_pkg::ctrl_cmd_t  cmd;
	spcs_pkg::dp_status_t sts;

	// Sequencer: IDLE takes a transfer, EXEC decides push/drop/tick/pop,
	// ANSWER waits for the queue read and the free result register.
	// A new item is taken while a previous result still sits in the
	// output register; EXEC stalls only if that result is still pending.
	spcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Datapath: per-class ring pointers over one shared memory,
	// priority pick of the highest non-empty class, busy countdown
	// and the result register that drives the output channel.
	spcs_dp #(
		.NUM_CLASSES (NUM_CLASSES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> sim/tb_strict_priority_call_server_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strict_priority_call_server_core
// Self-checking bench for the strict priority call server. A predictor keeps
// its own class queues and busy countdown. Every transfer into the block
// pushes one predicted outcome, and every result transfer is compared
// against the oldest one. Directed cases come first, then randomized traffic
// phases, an output hold-off and a longest-duration case.
// ----------------------------------------------------------------------------
module tb_strict_priority_call_server_core;

	localparam int NUM_CLASSES  = spcs_pkg::NUM_CLASSES_DEF;
	localparam int QUEUE_DEPTH  = spcs_pkg::QUEUE_DEPTH_DEF;
	localparam int ENTRY_W      = spcs_pkg::ENTRY_W;
	localparam int ID_W         = spcs_pkg::ID_W;
	localparam int CLASS_W      = spcs_pkg::CLASS_W;
	localparam int DUR_W        = spcs_pkg::DUR_W;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int PHASE_ITEMS  = 130;
	localparam int DRAIN_CYCLES = 10;

	// receiver stall styles
	localparam int RX_ALWAYS  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_ready;
	spcs_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	spcs_pkg::result_t result;

	// predictor state: waiting calls per class as {id, duration}
	logic [ENTRY_W-1:0] class_queue [NUM_CLASSES][$];
	logic [DUR_W-1:0]   busy_left = '0;

	spcs_pkg::result_t due_outcomes [$];
	spcs_pkg::result_t head_outcome;

	int fail_count   = 0;
	int cycle_count  = 0;
	int n_offered    = 0;
	int n_queued     = 0;
	int n_dropped    = 0;
	int n_answered   = 0;
	int n_no_answer  = 0;

	int          rx_mode       = RX_ALWAYS;
	int          rx_phase      = 0;
	int          hold_request  = 0;
	int          hold_left     = 0;
	logic [15:0] stall_pattern = 16'b1011_0011_1110_0101;

	strict_priority_call_server_core #(
		.NUM_CLASSES(NUM_CLASSES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one step of the call server: update queues/countdown, return the outcome
	function automatic spcs_pkg::result_t server_step(input spcs_pkg::item_t it);
		spcs_pkg::result_t  r;
		logic [ENTRY_W-1:0] word;
		logic [DUR_W-1:0]   d;
		logic               found;
		r     = '0;
		found = 1'b0;
		if (it.mode == spcs_pkg::MODE_ARRIVAL) begin
			r.answered_id    = it.caller_id;
			r.answered_class = it.call_class;
			// missing class behaves like a full queue
			if (int'(it.call_class) >= NUM_CLASSES ||
			    class_queue[it.call_class].size() >= QUEUE_DEPTH) begin
				r.result_kind = spcs_pkg::KIND_DROPPED;
			end else begin
				class_queue[it.call_class].push_back({it.caller_id, it.call_duration});
				r.result_kind = spcs_pkg::KIND_QUEUED;
			end
		end else if (busy_left != 0) begin
			busy_left     = busy_left - 1'b1;
			r.result_kind = spcs_pkg::KIND_NO_ANSWER;
		end else begin
			r.result_kind = spcs_pkg::KIND_NO_ANSWER;
			for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
				if (!found && class_queue[c].size() != 0) begin
					found = 1'b1;
					word  = class_queue[c].pop_front();
					d     = word[DUR_W-1:0];
					if (d == 0)
						d = DUR_W'(1);	// zero duration is served as one tick
					busy_left        = d - 1'b1;
					r.result_kind    = spcs_pkg::KIND_ANSWERED;
					r.answered_id    = word[ENTRY_W-1:DUR_W];
					r.answered_class = CLASS_W'(c);
				end
			end
		end
		r.server_busy = (busy_left != 0);
		return r;
	endfunction

	function automatic spcs_pkg::item_t make_arrival(input logic [ID_W-1:0] id,
	                                                 input logic [CLASS_W-1:0] cls,
	                                                 input logic [DUR_W-1:0] dur);
		spcs_pkg::item_t it;
		it.mode          = spcs_pkg::MODE_ARRIVAL;
		it.caller_id     = id;
		it.call_class    = cls;
		it.call_duration = dur;
		return it;
	endfunction

	// tick with random payload, which the block must ignore
	function automatic spcs_pkg::item_t make_tick();
		spcs_pkg::item_t it;
		it.mode          = spcs_pkg::MODE_TICK;
		it.caller_id     = ID_W'($urandom);
		it.call_class    = CLASS_W'($urandom);
		it.call_duration = DUR_W'($urandom);
		return it;
	endfunction

	// drive one item at the falling edge, hold until the transfer, predict it
	task automatic offer_item(input spcs_pkg::item_t it);
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		due_outcomes.push_back(server_step(it));
		n_offered++;
	endtask

	task automatic release_input(input int cycles);
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_outcomes();
		release_input(0);
		while (due_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: stall style plus an optional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: result_ready <= 1'b1;
					RX_RANDOM: result_ready <= ($urandom_range(0, 99) < 70);
					default: begin
						result_ready <= stall_pattern[rx_phase % 16];
						rx_phase++;
					end
				endcase
			end
		end
	end

	// result checker: in-order compare against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_outcomes.size() == 0) begin
				$error("result with nothing outstanding: kind %0d id %h class %0d busy %0b",
				       result.result_kind, result.answered_id,
				       result.answered_class, result.server_busy);
				fail_count++;
			end else begin
				head_outcome = due_outcomes.pop_front();
				if (result.result_kind !== head_outcome.result_kind) begin
					$error("result_kind: expected %0d actual %0d",
					       head_outcome.result_kind, result.result_kind);
					fail_count++;
				end
				if (result.answered_id !== head_outcome.answered_id) begin
					$error("answered_id: expected %h actual %h",
					       head_outcome.answered_id, result.answered_id);
					fail_count++;
				end
				if (result.answered_class !== head_outcome.answered_class) begin
					$error("answered_class: expected %0d actual %0d",
					       head_outcome.answered_class, result.answered_class);
					fail_count++;
				end
				if (result.server_busy !== head_outcome.server_busy) begin
					$error("server_busy: expected %0b actual %0b",
					       head_outcome.server_busy, result.server_busy);
					fail_count++;
				end
			end
			case (result.result_kind)
				spcs_pkg::KIND_QUEUED:   n_queued++;
				spcs_pkg::KIND_DROPPED:  n_dropped++;
				spcs_pkg::KIND_ANSWERED: n_answered++;
				default:                 n_no_answer++;
			endcase
		end
	end

	// ticks with every queue empty and the server idle
	task automatic test_idle_ticks();
		spcs_pkg::item_t it;
		rx_mode = RX_RANDOM;
		it = make_tick();
		it.caller_id     = '1;
		it.call_class    = '1;
		it.call_duration = '1;
		offer_item(it);
		offer_item(make_tick());
	endtask

	// one call per class, served highest class first; busy ticks; zero duration
	task automatic test_priority_order();
		offer_item(make_arrival(16'h0000, 2'd0, 16'd0));
		offer_item(make_arrival(16'hFFFF, 2'd3, 16'd3));
		offer_item(make_arrival(16'h1234, 2'd1, 16'd1));
		offer_item(make_arrival(16'hA5A5, 2'd2, 16'd2));
		repeat (8) offer_item(make_tick());
	endtask

	// fill one class to the brim, then two arrivals that must be dropped
	task automatic test_full_queue();
		for (int i = 0; i < QUEUE_DEPTH; i++)
			offer_item(make_arrival(ID_W'(16'h0100 + i), 2'd1, 16'd1));
		offer_item(make_arrival(16'hFFFF, 2'd1, 16'hFFFF));
		offer_item(make_arrival(16'h0000, 2'd1, 16'h8000));
	endtask

	// random phases cycling through arrival-heavy, balanced and tick-heavy traffic
	task automatic test_random_traffic();
		int          sent;
		int          arrival_pct;
		int          burst;
		logic [1:0]  cls;
		logic [15:0] dur;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ((sent / PHASE_ITEMS) % 3)
				0:       arrival_pct = 80;
				1:       arrival_pct = 50;
				default: arrival_pct = 25;
			endcase
			rx_mode = (sent / PHASE_ITEMS) % 3;
			burst   = $urandom_range(1, 20);
			repeat (burst) begin
				if ($urandom_range(0, 99) < arrival_pct) begin
					cls = CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
					// full-range durations only where the arrival is sure to drop
					if (class_queue[cls].size() >= QUEUE_DEPTH)
						dur = DUR_W'($urandom);
					else if ($urandom_range(0, 19) == 0)
						dur = DUR_W'($urandom_range(6, 40));
					else
						dur = DUR_W'($urandom_range(0, 5));
					offer_item(make_arrival(ID_W'($urandom), cls, dur));
				end else begin
					offer_item(make_tick());
				end
				sent++;
			end
			// some bursts run straight into the next one
			if ($urandom_range(0, 4) != 0)
				release_input($urandom_range(0, 6));
		end
		wait_outcomes();
	endtask

	// receiver holds off while the sender keeps pushing, so input stalls
	task automatic test_output_backpressure();
		rx_mode = RX_ALWAYS;
		offer_item(make_tick());
		hold_request = 300;
		for (int i = 0; i < 30; i++) begin
			if (i % 2 == 0)
				offer_item(make_arrival(ID_W'($urandom), CLASS_W'($urandom),
				                        DUR_W'($urandom_range(0, 2))));
			else
				offer_item(make_tick());
		end
		wait_outcomes();
	endtask

	// the longest service duration, answered and counted down a few ticks
	task automatic test_max_duration();
		rx_mode = RX_PATTERN;
		// empty the top class and the server so the long call is taken next
		while (busy_left != 0 || class_queue[3].size() != 0)
			offer_item(make_tick());
		offer_item(make_arrival(16'hFFFF, 2'd3, 16'hFFFF));
		offer_item(make_arrival(16'h0000, 2'd0, 16'd0));
		offer_item(make_tick());
		repeat (6) offer_item(make_tick());
	endtask

	task automatic finish_run();
		wait_outcomes();
		$display("Run covered %0d transfers: %0d queued, %0d dropped, %0d answered,",
		         n_offered, n_queued, n_dropped, n_answered);
		$display("%0d ticks without answer, across stall styles and an output hold-off.",
		         n_no_answer);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_idle_ticks();
		test_priority_order();
		test_full_queue();
		test_random_traffic();
		test_output_backpressure();
		test_max_duration();
		finish_run();
	end

endmodule

>>> files.f
rtl/spcs_pkg.sv
rtl/spcs_ctrl.sv
rtl/spcs_dp.sv
rtl/strict_priority_call_server_core.sv
sim/tb_strict_priority_call_server_core.sv
